@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion on the clk edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// Types, character codes and classification helpers for the source text
// tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Token kinds carried on the output request.
  localparam logic [1:0] KIND_IDENT  = 2'd0;
  localparam logic [1:0] KIND_NUMBER = 2'd1;
  localparam logic [1:0] KIND_SYMBOL = 2'd2;

  // Characters that steer the scanner.
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_IDENT      = 3'd1,
    MODE_NUMBER     = 3'd2,
    MODE_COLON      = 3'd3,
    MODE_SLASH      = 3'd4,
    MODE_BLOCK      = 3'd5,
    MODE_BLOCK_STAR = 3'd6,
    MODE_LINE       = 3'd7
  } scan_mode_t;

  // One input request: a source byte or the end-of-text mark.
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } stt_in_t;

  // One output request: a single token character.
  typedef struct packed {
    logic [7:0] token_char;
    logic [1:0] token_kind;
    logic       token_end;
    logic       run_end;
  } stt_out_t;

  // What a fresh byte does when the scanner is idle.
  typedef struct packed {
    scan_mode_t mode;
    logic [7:0] held;
    logic       sym;
  } stt_start_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_single_symbol(input logic [7:0] c);
    return c == 8'h2B || c == 8'h2D || c == CH_STAR || c == CH_EQUAL ||
           c == 8'h5B || c == 8'h5D || c == 8'h28 || c == 8'h29 ||
           c == 8'h2C || c == 8'h3B;
  endfunction

  // Classifies a byte seen in idle mode.
  function automatic stt_start_t start_byte(input logic [7:0] c);
    stt_start_t s;
    s.mode = MODE_IDLE;
    s.held = 8'h00;
    s.sym  = 1'b0;
    if (is_letter(c)) begin
      s.mode = MODE_IDENT;
      s.held = c;
    end else if (is_digit(c)) begin
      s.mode = MODE_NUMBER;
      s.held = c;
    end else if (c == CH_COLON) begin
      s.mode = MODE_COLON;
      s.held = c;
    end else if (c == CH_SLASH) begin
      s.mode = MODE_SLASH;
      s.held = c;
    end else if (is_single_symbol(c)) begin
      s.sym = 1'b1;
    end
    return s;
  endfunction

endpackage

@@ hdl/source_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer that turns source bytes into tagged token characters.
// ----------------------------------------------------------------------------
// Usage:
//   The src channel takes one request per byte (src_req.ch) or an end-of-text
//   request (src_req.end_of_text = 1), which flushes a pending token. The tok
//   channel gives one request per token character, tagged with its kind, an
//   end-of-token mark and a run_end mark on the last character caused by one
//   source request. A source request causes zero, one or two characters.
//   Identifier and number characters leave one source request late, since
//   the following byte decides where the token ends.
//   A character is written into the result queue when the source request
//   that caused it is accepted, and leaves on tok from the queue head.
//   Throughput: one source request per cycle while each causes at most one
//   character and src_stall is low; the tok side drains one character per
//   cycle while tok_stall is low, so a run of two-character requests
//   (such as ':=' or a token followed by a symbol) is limited by the
//   output rate. A four-entry result queue sets this: src_stall rises when
//   fewer than two entries are free. Reset empties the queue and returns
//   the scanner to idle. When the receiver stalls, the head character holds
//   on tok_req and the queue fills until src_stall rises.
// ----------------------------------------------------------------------------
module source_text_tokenizer
  import stt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_stall,
  input  stt_in_t  src_req,
  output logic     tok_valid,
  input  logic     tok_stall,
  output stt_out_t tok_req
);

  // Scanner state.
  scan_mode_t scan_mode, scan_mode_next;
  logic [7:0] held_char, held_char_next;

  // Result queue.
  stt_out_t   queue [4];
  logic [1:0] head, tail;
  logic [2:0] count, count_next;

  // Results of the current source request.
  stt_out_t   res0, res1;
  logic [1:0] res_num;

  logic accept, pop;

  stt_start_t st;
  logic       restart;
  stt_out_t   first;
  logic       first_vld;

  assign accept    = src_valid && !src_stall;
  assign pop       = tok_valid && !tok_stall;
  assign src_stall = (count > 3'd2);
  assign tok_valid = (count != 3'd0);
  assign tok_req   = queue[head];

  // Scanner step: next mode, held character and up to two results.
  always_comb begin
    st             = start_byte(src_req.ch);
    scan_mode_next = scan_mode;
    held_char_next = held_char;
    restart        = 1'b0;
    first          = '0;
    first_vld      = 1'b0;
    res0           = '0;
    res1           = '0;
    res_num        = 2'd0;

    if (src_req.end_of_text) begin
      scan_mode_next = MODE_IDLE;
      held_char_next = 8'h00;
      case (scan_mode)
        MODE_IDENT: begin
          first     = '{held_char, KIND_IDENT, 1'b1, 1'b0};
          first_vld = 1'b1;
        end
        MODE_NUMBER: begin
          first     = '{held_char, KIND_NUMBER, 1'b1, 1'b0};
          first_vld = 1'b1;
        end
        MODE_COLON: begin
          first     = '{CH_COLON, KIND_SYMBOL, 1'b1, 1'b0};
          first_vld = 1'b1;
        end
        MODE_SLASH: begin
          first     = '{CH_SLASH, KIND_SYMBOL, 1'b1, 1'b0};
          first_vld = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (scan_mode)
        MODE_IDENT: begin
          first_vld = 1'b1;
          if (is_letter(src_req.ch) || is_digit(src_req.ch)) begin
            first          = '{held_char, KIND_IDENT, 1'b0, 1'b0};
            held_char_next = src_req.ch;
          end else begin
            first   = '{held_char, KIND_IDENT, 1'b1, 1'b0};
            restart = 1'b1;
          end
        end
        MODE_NUMBER: begin
          first_vld = 1'b1;
          if (is_digit(src_req.ch)) begin
            first          = '{held_char, KIND_NUMBER, 1'b0, 1'b0};
            held_char_next = src_req.ch;
          end else begin
            first   = '{held_char, KIND_NUMBER, 1'b1, 1'b0};
            restart = 1'b1;
          end
        end
        MODE_COLON: begin
          first_vld = 1'b1;
          if (src_req.ch == CH_EQUAL) begin
            // Assignment operator: both characters leave now.
            first          = '{CH_COLON, KIND_SYMBOL, 1'b0, 1'b0};
            scan_mode_next = MODE_IDLE;
            held_char_next = 8'h00;
          end else begin
            first   = '{CH_COLON, KIND_SYMBOL, 1'b1, 1'b0};
            restart = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (src_req.ch == CH_STAR) begin
            scan_mode_next = MODE_BLOCK;
            held_char_next = 8'h00;
          end else if (src_req.ch == CH_SLASH) begin
            scan_mode_next = MODE_LINE;
            held_char_next = 8'h00;
          end else begin
            first     = '{CH_SLASH, KIND_SYMBOL, 1'b1, 1'b0};
            first_vld = 1'b1;
            restart   = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (src_req.ch == CH_STAR) begin
            scan_mode_next = MODE_BLOCK_STAR;
          end
        end
        MODE_BLOCK_STAR: begin
          if (src_req.ch == CH_SLASH) begin
            scan_mode_next = MODE_IDLE;
          end else if (src_req.ch != CH_STAR) begin
            scan_mode_next = MODE_BLOCK;
          end
        end
        MODE_LINE: begin
          if (src_req.ch == CH_NEWLINE) begin
            scan_mode_next = MODE_IDLE;
          end
        end
        MODE_IDLE: begin
          restart = 1'b1;
        end
      endcase
    end

    // The byte that ended a token is taken again as a fresh byte.
    if (restart) begin
      scan_mode_next = st.mode;
      held_char_next = st.held;
    end

    // Pack the results in order and mark the last one.
    if (first_vld) begin
      res0    = first;
      res_num = 2'd1;
      if (!src_req.end_of_text && scan_mode == MODE_COLON &&
          src_req.ch == CH_EQUAL) begin
        res1    = '{CH_EQUAL, KIND_SYMBOL, 1'b1, 1'b1};
        res_num = 2'd2;
      end else if (restart && st.sym) begin
        res1    = '{src_req.ch, KIND_SYMBOL, 1'b1, 1'b1};
        res_num = 2'd2;
      end else begin
        res0.run_end = 1'b1;
      end
    end else if (restart && st.sym) begin
      res0    = '{src_req.ch, KIND_SYMBOL, 1'b1, 1'b1};
      res_num = 2'd1;
    end
  end

  // Queue occupancy.
  always_comb begin
    count_next = count;
    if (accept) begin
      count_next = count_next + {1'b0, res_num};
    end
    if (pop) begin
      count_next = count_next - 3'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_IDLE;
      held_char <= 8'h00;
      head      <= 2'd0;
      tail      <= 2'd0;
      count     <= 3'd0;
    end else begin
      count <= count_next;
      if (accept) begin
        scan_mode <= scan_mode_next;
        held_char <= held_char_next;
        tail      <= tail + res_num;
      end
      if (pop) begin
        head <= head + 2'd1;
      end
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    if (accept && res_num != 2'd0) begin
      queue[tail] <= res0;
      if (res_num == 2'd2) begin
        queue[tail + 2'd1] <= res1;
      end
    end
  end

endmodule

@@ hdl/stt_checker.sv @@
// ----------------------------------------------------------------------------
// stt_checker
// Port-level assertions for the source text tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stt_checker
  import stt_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     src_valid,
  input logic     src_stall,
  input logic     tok_valid,
  input logic     tok_stall,
  input stt_out_t tok_req
);

  // Handshake terms shared by the properties below.
  logic src_take;
  logic tok_held;
  logic num_char;

  assign src_take = src_valid && !src_stall;
  assign tok_held = tok_valid && tok_stall;
  assign num_char = tok_valid && tok_req.token_kind == KIND_NUMBER;

  // Reset empties the result queue.
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !tok_valid, "output valid after reset")

  // A stalled output request holds.
  `ASSERT_RUN(a_tok_hold, tok_held |=> tok_valid && $stable(tok_req), "stalled request changed")

  // The kind code is never the unused value.
  `ASSERT_RUN(a_kind_legal, tok_valid |-> tok_req.token_kind != 2'd3, "illegal token kind")

  // Number characters are decimal digits.
  `ASSERT_RUN(a_number_digit, num_char |-> is_digit(tok_req.token_char), "non-digit number")

  // An idle queue with nothing accepted stays idle.
  `ASSERT_RUN(a_no_spurious, !tok_valid && !src_take |=> !tok_valid, "result without a request")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

@@ bench/stt_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_result_checker
// Watches both channels of the source text tokenizer, predicts the token
// characters that each accepted source request causes, and compares every
// accepted token request with the oldest prediction.
// ----------------------------------------------------------------------------
module stt_result_checker
  import stt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  input  logic     src_stall,
  input  stt_in_t  src_req,
  input  logic     tok_valid,
  input  logic     tok_stall,
  input  stt_out_t tok_req,
  output int       fail_count,
  output int       pending_count
);

  localparam int MAX_PRINTS = 40;

  // How a byte can start or continue a token.
  typedef enum logic [2:0] {
    BC_OTHER,
    BC_LETTER,
    BC_DIGIT,
    BC_COLON,
    BC_SLASH,
    BC_SYMBOL
  } byte_class_t;

  // Scanner state of the prediction.
  scan_mode_t mode_q;
  logic [7:0] held_q;

  // Token characters caused by the current source request.
  stt_out_t   run_buf [2];
  int         run_len;

  // Token characters predicted but not yet seen on the output.
  stt_out_t   expected_chars [$];
  int         n_results;

  function automatic byte_class_t classify(input logic [7:0] c);
    byte_class_t cls;
    cls = BC_OTHER;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE) begin
      cls = BC_LETTER;
    end else if (c >= "0" && c <= "9") begin
      cls = BC_DIGIT;
    end else begin
      case (c)
        CH_COLON: cls = BC_COLON;
        CH_SLASH: cls = BC_SLASH;
        "+", "-", CH_STAR, CH_EQUAL, "[", "]", "(", ")", ",", ";": cls = BC_SYMBOL;
        default: cls = BC_OTHER;
      endcase
    end
    return cls;
  endfunction

  task automatic push_char(input logic [7:0] c, input logic [1:0] kind, input logic last);
    stt_out_t r;
    r.token_char = c;
    r.token_kind = kind;
    r.token_end  = last;
    r.run_end    = 1'b0;
    run_buf[run_len] = r;
    run_len++;
  endtask

  // A byte seen as if the scanner were idle.
  task automatic take_fresh(input logic [7:0] c);
    byte_class_t cls;
    cls    = classify(c);
    mode_q = MODE_IDLE;
    held_q = 8'h00;
    case (cls)
      BC_LETTER: begin
        mode_q = MODE_IDENT;
        held_q = c;
      end
      BC_DIGIT: begin
        mode_q = MODE_NUMBER;
        held_q = c;
      end
      BC_COLON: begin
        mode_q = MODE_COLON;
        held_q = c;
      end
      BC_SLASH: begin
        mode_q = MODE_SLASH;
        held_q = c;
      end
      BC_SYMBOL: push_char(c, KIND_SYMBOL, 1'b1);
      default: ;
    endcase
  endtask

  // Works out the token characters of one source request and queues them.
  task automatic predict_token_chars(input stt_in_t req);
    byte_class_t cls;
    logic [7:0]  c;
    run_len = 0;
    c       = req.ch;
    cls     = classify(c);
    if (req.end_of_text) begin
      // Flush whatever is pending; an open comment is simply dropped.
      case (mode_q)
        MODE_IDENT:  push_char(held_q, KIND_IDENT, 1'b1);
        MODE_NUMBER: push_char(held_q, KIND_NUMBER, 1'b1);
        MODE_COLON:  push_char(CH_COLON, KIND_SYMBOL, 1'b1);
        MODE_SLASH:  push_char(CH_SLASH, KIND_SYMBOL, 1'b1);
        default: ;
      endcase
      mode_q = MODE_IDLE;
      held_q = 8'h00;
    end else begin
      case (mode_q)
        MODE_IDENT: begin
          if (cls == BC_LETTER || cls == BC_DIGIT) begin
            push_char(held_q, KIND_IDENT, 1'b0);
            held_q = c;
          end else begin
            push_char(held_q, KIND_IDENT, 1'b1);
            take_fresh(c);
          end
        end
        MODE_NUMBER: begin
          if (cls == BC_DIGIT) begin
            push_char(held_q, KIND_NUMBER, 1'b0);
            held_q = c;
          end else begin
            push_char(held_q, KIND_NUMBER, 1'b1);
            take_fresh(c);
          end
        end
        MODE_COLON: begin
          if (c == CH_EQUAL) begin
            push_char(CH_COLON, KIND_SYMBOL, 1'b0);
            push_char(CH_EQUAL, KIND_SYMBOL, 1'b1);
            mode_q = MODE_IDLE;
            held_q = 8'h00;
          end else begin
            push_char(CH_COLON, KIND_SYMBOL, 1'b1);
            take_fresh(c);
          end
        end
        MODE_SLASH: begin
          if (c == CH_STAR) begin
            mode_q = MODE_BLOCK;
            held_q = 8'h00;
          end else if (c == CH_SLASH) begin
            mode_q = MODE_LINE;
            held_q = 8'h00;
          end else begin
            push_char(CH_SLASH, KIND_SYMBOL, 1'b1);
            take_fresh(c);
          end
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) mode_q = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          // Any run of stars may end in the closing slash.
          if (c == CH_SLASH) mode_q = MODE_IDLE;
          else if (c != CH_STAR) mode_q = MODE_BLOCK;
        end
        MODE_LINE: begin
          if (c == CH_NEWLINE) mode_q = MODE_IDLE;
        end
        default: take_fresh(c);
      endcase
    end
    if (run_len > 0) run_buf[run_len - 1].run_end = 1'b1;
    for (int i = 0; i < run_len; i++) expected_chars.push_back(run_buf[i]);
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Compares one token request with the oldest prediction.
  task automatic check_token_char(input stt_out_t got);
    stt_out_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("token request %0d with nothing predicted: char %h",
                                n_results, got.token_char));
    end else begin
      want = expected_chars.pop_front();
      if (got.token_char !== want.token_char || got.token_kind !== want.token_kind ||
          got.token_end !== want.token_end || got.run_end !== want.run_end) begin
        report_mismatch($sformatf(
          "token request %0d: char %h kind %0d end %b run %b, expected %h %0d %b %b",
          n_results, got.token_char, got.token_kind, got.token_end, got.run_end,
          want.token_char, want.token_kind, want.token_end, want.run_end));
      end
    end
    n_results++;
  endtask

  // Results are registered in the block's queue before they leave, so the
  // output side is checked before this edge's prediction is queued.
  always @(posedge clk) begin
    if (rst) begin
      mode_q     = MODE_IDLE;
      held_q     = 8'h00;
      n_results  = 0;
      fail_count = 0;
      expected_chars.delete();
    end else begin
      if (tok_valid && !tok_stall) check_token_char(tok_req);
      if (src_valid && !src_stall) predict_token_chars(src_req);
    end
    pending_count <= expected_chars.size();
  end

endmodule

@@ bench/tb_source_text_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer
// Drives the source text tokenizer with a short directed text and then with
// random well-formed fragments mixed with noise, under random idling and
// one long receiver hold-off. The checker beside the block does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;
  import stt_pkg::*;

  localparam int IDLE_PCT     = 11;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_START   = 600;
  localparam int HOLD_LEN     = 300;
  localparam int QUIET_START  = 1400;
  localparam int QUIET_LEN    = 400;
  localparam int SRC_QUIET_LO = 700;
  localparam int SRC_QUIET_HI = 1000;
  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  localparam string LETTERS = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
  localparam string DIGITS  = "0123456789";
  localparam string SYMBOLS = "+-*=[]/(),;";
  localparam string SPACES  = " \t\n";

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_stall;
  stt_in_t  src_req   = '0;
  logic     tok_valid;
  logic     tok_stall = 1'b0;
  stt_out_t tok_req;

  int       fail_count;
  int       pending_count;
  int       n_items   = 0;
  int       stuck_cycles;
  logic     src_quiet = 1'b0;

  always #5 clk = ~clk;

  source_text_tokenizer u_top (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_req  (src_req),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall),
    .tok_req  (tok_req)
  );

  stt_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .src_req      (src_req),
    .tok_valid    (tok_valid),
    .tok_stall    (tok_stall),
    .tok_req      (tok_req),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // Offers one source request after an optional random gap and waits until
  // it is taken. Called and returning at a rising edge.
  task automatic send_req(input stt_in_t req, input bit counted);
    while (!src_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_req   <= req;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    if (counted) n_items++;
  endtask

  task automatic send_byte(input logic [7:0] c, input bit counted = 1'b1);
    stt_in_t req;
    req.ch          = c;
    req.end_of_text = 1'b0;
    send_req(req, counted);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_eot();
    stt_in_t req;
    req.ch          = 8'($urandom_range(0, 255));
    req.end_of_text = 1'b1;
    send_req(req, 1'b1);
  endtask

  // One random piece of source text: mostly well-formed tokens, comments
  // and separators, with some raw noise and unknown bytes.
  task automatic send_fragment();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      len = $urandom_range(0, 7);
      send_byte(LETTERS[$urandom_range(0, LETTERS.len() - 1)]);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 2) == 0) send_byte(DIGITS[$urandom_range(0, 9)]);
        else send_byte(LETTERS[$urandom_range(0, LETTERS.len() - 1)]);
      end
    end else if (pick < 40) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_byte(DIGITS[$urandom_range(0, 9)]);
    end else if (pick < 48) begin
      send_text(":=");
    end else if (pick < 52) begin
      send_byte(CH_COLON);
    end else if (pick < 64) begin
      send_byte(SYMBOLS[$urandom_range(0, SYMBOLS.len() - 1)]);
    end else if (pick < 72) begin
      // Block comment; the body is ignored by the block.
      send_text("/*");
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) send_byte(CH_STAR, 1'b0);
        else send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) send_byte(CH_STAR);
      send_byte(CH_SLASH);
    end else if (pick < 76) begin
      send_text("//");
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(CH_NEWLINE);
    end else if (pick < 86) begin
      send_byte(SPACES[$urandom_range(0, 2)], 1'b0);
    end else if (pick < 90) begin
      if ($urandom_range(0, 3) == 0) send_byte(8'h0D);
      else send_byte(8'($urandom_range(128, 255)));
    end else if (pick < 93) begin
      send_eot();
    end else begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver: random stalls, one long hold-off that backs the block up,
  // and one stretch with no stalls at all.
  initial begin : tok_sink
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) tok_stall <= 1'b1;
      else if (cyc >= QUIET_START && cyc < QUIET_START + QUIET_LEN) tok_stall <= 1'b0;
      else tok_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Ends the run when neither channel has moved a request for too long.
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else if ((src_valid && !src_stall) || (tok_valid && !tok_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Identifier extremes, tab as separator, number running into a letter.
    send_text("_Z9\t");
    send_text("09a");
    // High unknown byte ends the identifier.
    send_byte(8'hFF);
    // Assignment, lone colon, lone slash.
    send_text(":=:]/-");
    // Block comment closed by a run of stars.
    send_text("/***/");
    // Line comment with a high byte inside.
    send_text("//");
    send_byte(8'h80, 1'b0);
    send_byte(CH_NEWLINE);
    // End of text flushes a pending identifier and a pending number.
    send_text("x");
    send_eot();
    send_text("7");
    send_eot();

    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      src_quiet <= (n_items >= SRC_QUIET_LO && n_items < SRC_QUIET_HI);
      send_fragment();
    end
    send_eot();
    src_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/stt_pkg.sv
hdl/source_text_tokenizer.sv
hdl/stt_checker.sv
bench/stt_result_checker.sv
bench/tb_source_text_tokenizer.sv
